@@ src/spq_pkg.sv @@
// Shared types and constants of the sorted priority queue.
package spq_pkg;

    localparam int SPQ_DEPTH     = 16;
    localparam int SPQ_ID_BITS   = 16;
    localparam int SPQ_PRIO_BITS = 16;

    localparam logic ACT_ENQ = 1'b0;
    localparam logic ACT_DEQ = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Command broadcast to every cell of the chain at once.
    typedef struct packed {
        logic enq;
        logic deq;
    } t_cell_ctrl;

endpackage

@@ src/spq_cell.sv @@
// One slot of the sorted chain: holds an entry and trades it with its neighbors.
module spq_cell #(
    parameter int ID_BITS   = spq_pkg::SPQ_ID_BITS,
    parameter int PRIO_BITS = spq_pkg::SPQ_PRIO_BITS
) (
    input  logic                 i_clk,
    input  spq_pkg::t_cell_ctrl  i_ctrl,
    input  logic                 i_occupied,
    input  logic [ID_BITS-1:0]   i_new_id,
    input  logic [PRIO_BITS-1:0] i_new_prio,
    input  logic                 i_left_stays,
    input  logic [ID_BITS-1:0]   i_left_id,
    input  logic [PRIO_BITS-1:0] i_left_prio,
    input  logic [ID_BITS-1:0]   i_right_id,
    input  logic [PRIO_BITS-1:0] i_right_prio,
    output logic                 o_stays,
    output logic [ID_BITS-1:0]   o_id,
    output logic [PRIO_BITS-1:0] o_prio
);
    import spq_pkg::*;

    logic [ID_BITS-1:0]   r_id;
    logic [PRIO_BITS-1:0] r_prio;
    logic [ID_BITS-1:0]   n_id;
    logic [PRIO_BITS-1:0] n_prio;
    logic                 stays;

    // An entry with an equal or smaller priority stays ahead of the new one.
    assign stays = i_occupied && (r_prio <= i_new_prio);

    always_comb begin
        n_id   = r_id;
        n_prio = r_prio;
        if (i_ctrl.enq) begin
            if (!stays) begin
                if (i_left_stays) begin
                    n_id   = i_new_id;
                    n_prio = i_new_prio;
                end else begin
                    n_id   = i_left_id;
                    n_prio = i_left_prio;
                end
            end
        end else if (i_ctrl.deq) begin
            n_id   = i_right_id;
            n_prio = i_right_prio;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id   <= n_id;
        r_prio <= n_prio;
    end

    assign o_stays = stays;
    assign o_id    = r_id;
    assign o_prio  = r_prio;

endmodule

@@ src/sorted_priority_queue_top.sv @@
// Sorted priority queue built as a chain of compare-and-shift cells.
//
// Input channel: i_valid / o_stall with i_action, i_item_id, i_item_priority.
// A beat is taken at a rising edge with i_valid high and o_stall low. Action
// enqueue inserts the entry behind every held entry of equal or smaller
// priority; action dequeue removes the head, the smallest priority value.
// Output channel: o_valid / i_stall with o_status, o_removed_id,
// o_removed_priority and o_fill_level, one result beat per input beat.
// The result is registered in the output register at the edge that takes the
// input beat. One beat is taken per cycle while the receiver does not stall,
// as every cell compares against the new entry and shifts in the same cycle.
// Enqueue when full answers status full, dequeue when empty answers status
// empty; neither changes the contents. Removed fields are zero unless a
// dequeue succeeds.
// While the receiver stalls with a result pending, o_stall is raised and the
// result holds. Reset empties the queue and drops any pending result; the
// slot contents are not cleared, because only filled slots are ever read.
module sorted_priority_queue_top #(
    parameter int DEPTH     = spq_pkg::SPQ_DEPTH,
    parameter int ID_BITS   = spq_pkg::SPQ_ID_BITS,
    parameter int PRIO_BITS = spq_pkg::SPQ_PRIO_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_action,
    input  logic [ID_BITS-1:0]           i_item_id,
    input  logic [PRIO_BITS-1:0]         i_item_priority,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [1:0]                   o_status,
    output logic [ID_BITS-1:0]           o_removed_id,
    output logic [PRIO_BITS-1:0]         o_removed_priority,
    output logic [$clog2(DEPTH+1)-1:0]   o_fill_level
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic                 r_out_valid;
    t_status              r_status;
    t_status              n_status;
    logic [ID_BITS-1:0]   r_rid;
    logic [ID_BITS-1:0]   n_rid;
    logic [PRIO_BITS-1:0] r_rprio;
    logic [PRIO_BITS-1:0] n_rprio;
    logic [CNT_W-1:0]     r_fill;

    logic                 in_acc;
    logic                 full;
    logic                 empty;
    t_cell_ctrl           ctrl;

    logic [DEPTH-1:0]     occ;
    logic [DEPTH-1:0]     stays;
    logic [ID_BITS-1:0]   cell_id   [DEPTH];
    logic [PRIO_BITS-1:0] cell_prio [DEPTH];

    assign o_stall = r_out_valid && i_stall;
    assign in_acc  = i_valid && !o_stall;
    assign full    = (r_count == CNT_W'(DEPTH));
    assign empty   = (r_count == '0);

    assign ctrl.enq = in_acc && (i_action == ACT_ENQ) && !full;
    assign ctrl.deq = in_acc && (i_action == ACT_DEQ) && !empty;

    genvar k;
    generate
        for (k = 0; k < DEPTH; k++) begin : g_cell
            logic                 left_stays;
            logic [ID_BITS-1:0]   left_id;
            logic [PRIO_BITS-1:0] left_prio;
            logic [ID_BITS-1:0]   right_id;
            logic [PRIO_BITS-1:0] right_prio;

            assign occ[k] = (CNT_W'(k) < r_count);

            if (k == 0) begin : g_head
                assign left_stays = 1'b1;
                assign left_id    = i_item_id;
                assign left_prio  = i_item_priority;
            end else begin : g_body
                assign left_stays = stays[k-1];
                assign left_id    = cell_id[k-1];
                assign left_prio  = cell_prio[k-1];
            end

            // The tail cell refills from itself; that slot is empty afterwards.
            if (k == DEPTH - 1) begin : g_tail
                assign right_id   = cell_id[k];
                assign right_prio = cell_prio[k];
            end else begin : g_inner
                assign right_id   = cell_id[k+1];
                assign right_prio = cell_prio[k+1];
            end

            spq_cell #(
                .ID_BITS   (ID_BITS),
                .PRIO_BITS (PRIO_BITS)
            ) u_cell (
                .i_clk        (i_clk),
                .i_ctrl       (ctrl),
                .i_occupied   (occ[k]),
                .i_new_id     (i_item_id),
                .i_new_prio   (i_item_priority),
                .i_left_stays (left_stays),
                .i_left_id    (left_id),
                .i_left_prio  (left_prio),
                .i_right_id   (right_id),
                .i_right_prio (right_prio),
                .o_stays      (stays[k]),
                .o_id         (cell_id[k]),
                .o_prio       (cell_prio[k])
            );
        end
    endgenerate

    always_comb begin
        n_count  = r_count;
        n_status = ST_DONE;
        n_rid    = '0;
        n_rprio  = '0;
        if (i_action == ACT_ENQ) begin
            if (full) begin
                n_status = ST_FULL;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end else begin
            if (empty) begin
                n_status = ST_EMPTY;
            end else begin
                n_count = r_count - CNT_W'(1);
                n_rid   = cell_id[0];
                n_rprio = cell_prio[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (in_acc) begin
            r_status <= n_status;
            r_rid    <= n_rid;
            r_rprio  <= n_rprio;
            r_fill   <= n_count;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_status           = r_status;
    assign o_removed_id       = r_rid;
    assign o_removed_priority = r_rprio;
    assign o_fill_level       = r_fill;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count exceeds depth");

    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CNT_W'(2)) |-> (cell_prio[0] <= cell_prio[1]))
        else $error("head entry is not the smallest priority");

    a_deq_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.deq |=> (o_valid && o_status == ST_DONE
                      && o_fill_level == CNT_W'($past(r_count) - CNT_W'(1))))
        else $error("dequeue result does not report the reduced fill level");

    a_reject_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !ctrl.enq && !ctrl.deq) |=> $stable(r_count))
        else $error("rejected request changed the entry count");

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench of the sorted priority queue: a directed table, then random traffic.
`timescale 1ns / 100ps

module testbench;
    import spq_pkg::*;

    localparam int ID_W            = SPQ_ID_BITS;
    localparam int PRIO_W          = SPQ_PRIO_BITS;
    localparam int FILL_W          = $clog2(SPQ_DEPTH + 1);
    localparam int RANDOM_REQUESTS = 750;
    localparam int IDLE_PCT        = 31;
    localparam int QUIET_LIMIT     = 1000;
    localparam logic [ID_W-1:0]   ID_MAX   = '1;
    localparam logic [PRIO_W-1:0] PRIO_MAX = '1;

    typedef struct packed {
        logic              act;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } t_request;

    typedef struct packed {
        t_status           st;
        logic [ID_W-1:0]   rid;
        logic [PRIO_W-1:0] rprio;
        logic [FILL_W-1:0] fill;
    } t_answer;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } t_entry;

    typedef struct packed {
        t_request req;
        logic     typed;
        t_answer  ans;
    } t_row;

    logic              i_clk           = 1'b0;
    logic              i_rst_n         = 1'b0;
    logic              i_valid         = 1'b0;
    logic              o_stall;
    logic              i_action        = ACT_ENQ;
    logic [ID_W-1:0]   i_item_id       = '0;
    logic [PRIO_W-1:0] i_item_priority = '0;
    logic              o_valid;
    logic              i_stall         = 1'b0;
    logic [1:0]        o_status;
    logic [ID_W-1:0]   o_removed_id;
    logic [PRIO_W-1:0] o_removed_priority;
    logic [FILL_W-1:0] o_fill_level;

    t_entry  held[$];
    t_answer answers_due[$];
    t_row    plan[$];
    int      errors       = 0;
    int      quiet_cycles = 0;
    bit      calm         = 1'b0;

    sorted_priority_queue_top dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_action           (i_action),
        .i_item_id          (i_item_id),
        .i_item_priority    (i_item_priority),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_status           (o_status),
        .o_removed_id       (o_removed_id),
        .o_removed_priority (o_removed_priority),
        .o_fill_level       (o_fill_level)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Applies one request to the local copy of the queue and returns its answer.
    function automatic t_answer queue_step(input t_request r);
        t_answer a;
        t_entry  e;
        int      pos;
        a = '0;
        a.st = ST_DONE;
        pos = 0;
        if (r.act == ACT_ENQ) begin
            if (held.size() >= SPQ_DEPTH) begin
                a.st = ST_FULL;
            end else begin
                // Equal priorities keep arrival order, so skip past them.
                while (pos < held.size() && held[pos].prio <= r.prio) pos++;
                e.id = r.id;
                e.prio = r.prio;
                held.insert(pos, e);
            end
        end else if (held.size() == 0) begin
            a.st = ST_EMPTY;
        end else begin
            e = held.pop_front();
            a.rid = e.id;
            a.rprio = e.prio;
        end
        a.fill = FILL_W'(held.size());
        return a;
    endfunction

    task automatic add_row(input logic act, input logic [ID_W-1:0] id,
                           input logic [PRIO_W-1:0] prio, input logic typed,
                           input t_status st, input logic [ID_W-1:0] rid,
                           input logic [PRIO_W-1:0] rprio, input int fill);
        t_row r;
        r.req.act = act;
        r.req.id = id;
        r.req.prio = prio;
        r.typed = typed;
        r.ans.st = st;
        r.ans.rid = rid;
        r.ans.rprio = rprio;
        r.ans.fill = FILL_W'(fill);
        plan.push_back(r);
    endtask

    task automatic send_request(input t_row row);
        t_answer predicted;
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_action <= row.req.act;
        i_item_id <= row.req.id;
        i_item_priority <= row.req.prio;
        do @(posedge i_clk); while (o_stall);
        predicted = queue_step(row.req);
        answers_due.push_back(row.typed ? row.ans : predicted);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_answer want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (answers_due.size() == 0) begin
                $display("%0t: result beat with nothing expected, status %0d fill %0d",
                         $time, o_status, o_fill_level);
                errors++;
            end else begin
                want = answers_due.pop_front();
                check_field("status", 32'(want.st), 32'(o_status));
                check_field("removed_id", 32'(want.rid), 32'(o_removed_id));
                check_field("removed_priority", 32'(want.rprio), 32'(o_removed_priority));
                check_field("fill_level", 32'(want.fill), 32'(o_fill_level));
            end
        end
        i_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        t_row r;
        int   stretch_left;
        int   enq_pct;
        stretch_left = 0;
        enq_pct = 50;

        // Empty queue, extremes of both fields, and the head leaving first.
        add_row(ACT_DEQ, '0,       '0,       1'b1, ST_EMPTY, '0, '0, 0);
        add_row(ACT_ENQ, ID_MAX,   PRIO_MAX, 1'b1, ST_DONE,  '0, '0, 1);
        add_row(ACT_ENQ, '0,       '0,       1'b1, ST_DONE,  '0, '0, 2);
        add_row(ACT_DEQ, '0,       '0,       1'b1, ST_DONE,  '0, '0, 1);
        add_row(ACT_DEQ, '0,       '0,       1'b1, ST_DONE,  ID_MAX, PRIO_MAX, 0);
        add_row(ACT_DEQ, ID_MAX,   PRIO_MAX, 1'b1, ST_EMPTY, '0, '0, 0);
        // Fill to capacity with ties, out-of-order priorities and both extremes.
        add_row(ACT_ENQ, 16'h0001, 16'd5,    1'b1, ST_DONE,  '0, '0, 1);
        add_row(ACT_ENQ, 16'h0002, 16'd5,    1'b1, ST_DONE,  '0, '0, 2);
        add_row(ACT_ENQ, 16'h0003, 16'd3,    1'b1, ST_DONE,  '0, '0, 3);
        add_row(ACT_ENQ, 16'hAAAA, 16'd5,    1'b1, ST_DONE,  '0, '0, 4);
        add_row(ACT_ENQ, 16'h5555, PRIO_MAX, 1'b1, ST_DONE,  '0, '0, 5);
        add_row(ACT_ENQ, 16'h0004, 16'd0,    1'b1, ST_DONE,  '0, '0, 6);
        add_row(ACT_ENQ, 16'h0005, 16'd3,    1'b1, ST_DONE,  '0, '0, 7);
        add_row(ACT_ENQ, 16'h0006, 16'h8000, 1'b1, ST_DONE,  '0, '0, 8);
        add_row(ACT_ENQ, 16'h0007, PRIO_MAX, 1'b1, ST_DONE,  '0, '0, 9);
        add_row(ACT_ENQ, 16'h0008, 16'd0,    1'b1, ST_DONE,  '0, '0, 10);
        add_row(ACT_ENQ, 16'h0009, 16'h7FFF, 1'b1, ST_DONE,  '0, '0, 11);
        add_row(ACT_ENQ, 16'h000A, 16'd5,    1'b1, ST_DONE,  '0, '0, 12);
        add_row(ACT_ENQ, 16'h000B, 16'd1,    1'b1, ST_DONE,  '0, '0, 13);
        add_row(ACT_ENQ, 16'h000C, 16'hFFFE, 1'b1, ST_DONE,  '0, '0, 14);
        add_row(ACT_ENQ, 16'h000D, 16'd2,    1'b1, ST_DONE,  '0, '0, 15);
        add_row(ACT_ENQ, ID_MAX,   16'd4,    1'b1, ST_DONE,  '0, '0, 16);
        add_row(ACT_ENQ, 16'h1234, 16'd0,    1'b1, ST_FULL,  '0, '0, 16);
        add_row(ACT_DEQ, '0,       '0,       1'b0, ST_DONE,  '0, '0, 0);
        add_row(ACT_DEQ, ID_MAX,   PRIO_MAX, 1'b0, ST_DONE,  '0, '0, 0);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[k]) send_request(plan[k]);

        // Stretches lean toward filling or draining so both full and empty are hit often.
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (stretch_left == 0) begin
                stretch_left = $urandom_range(40, 10);
                case ($urandom_range(2))
                    0: enq_pct = 80;
                    1: enq_pct = 20;
                    default: enq_pct = 50;
                endcase
            end
            stretch_left--;
            calm = (n >= 300 && n < 450);
            r = '0;
            r.req.act = ($urandom_range(99) < enq_pct) ? ACT_ENQ : ACT_DEQ;
            r.req.id = ID_W'($urandom);
            case ($urandom_range(3))
                0: r.req.prio = PRIO_W'($urandom_range(7));
                1: r.req.prio = $urandom_range(1) ? PRIO_MAX : '0;
                default: r.req.prio = PRIO_W'($urandom);
            endcase
            send_request(r);
        end
        i_valid <= 1'b0;
        calm = 1'b0;

        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        if (errors == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end

endmodule
